/* rtl/core/whole_word_replace_stream_macros.svh */
// assertion macros used by the whole_word_replace_stream rtl
// expects clk and rst in the scope of each use
`ifndef WHOLE_WORD_REPLACE_STREAM_MACROS_SVH
`define WHOLE_WORD_REPLACE_STREAM_MACROS_SVH

// same-cycle implication
`define WWR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/wwr_pkg.sv */
// package for whole_word_replace_stream: widths, character codes,
// register indexes, config bundle and sequencer states; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wwr_pkg;

  localparam int WORD_W    = 64;
  localparam int LEN_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_EOT   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIND_WORD      = 2'd0,
    REG_FIND_LENGTH    = 2'd1,
    REG_REPLACE_WORD   = 2'd2,
    REG_REPLACE_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] find_word;
    logic [LEN_W-1:0]  find_length;
    logic [WORD_W-1:0] replace_word;
    logic [LEN_W-1:0]  replace_length;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_EMIT_STORE,
    S_EMIT_REPL,
    S_EMIT_BYTE
  } state_t;

  function automatic logic is_delim(input logic [BYTE_W-1:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_EOT);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/wwr_store.sv */
// word store: small byte array holding the current word, registered read
// depends on wwr_pkg
`timescale 1ns / 1ps
`default_nettype none

module wwr_store
  import wwr_pkg::*;
#(
  parameter int FIND_MAX = 8,
  localparam int ADDR_W = (FIND_MAX > 1) ? $clog2(FIND_MAX) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [FIND_MAX];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/core/wwr_ctrl.sv */
// sequencer for whole_word_replace_stream: byte compare unit, word count,
// output register; depends on wwr_pkg, wwr_store port, macros header
`timescale 1ns / 1ps
`default_nettype none

`include "whole_word_replace_stream_macros.svh"

module wwr_ctrl
  import wwr_pkg::*;
#(
  parameter int FIND_MAX    = 8,
  parameter int REPLACE_MAX = 8,
  localparam int SA_W = (FIND_MAX > 1) ? $clog2(FIND_MAX) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] text_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              run_last,
  output logic              st_wr_en,
  output logic [SA_W-1:0]   st_wr_addr,
  output logic [BYTE_W-1:0] st_wr_data,
  output logic [SA_W-1:0]   st_rd_addr,
  input  logic [BYTE_W-1:0] st_rd_data
);

  localparam int MAXL  = (FIND_MAX > REPLACE_MAX) ? FIND_MAX : REPLACE_MAX;
  localparam int LW    = $clog2(MAXL + 1);
  localparam int CNT_W = $clog2(FIND_MAX + 1);
  localparam int RA_W  = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  state_t            state, state_next;
  logic [LW-1:0]     pos, pos_next;
  logic [LW-1:0]     lim, lim_next;
  logic [BYTE_W-1:0] held_byte, held_byte_next;
  logic [CNT_W-1:0]  word_count, word_count_next;
  logic              overlong, overlong_next;

  logic [LW-1:0]     flen, rlen, cnt_eff;
  logic              accept, in_delim, out_free;
  logic              pos_last_s, pos_last_r, byte_match;
  logic              load, emit_last;
  logic [BYTE_W-1:0] emit_byte;

  // effective lengths
  always_comb begin
    if (cfg.find_length == '0) begin
      flen = LW'(1);
    end else if (32'(cfg.find_length) > FIND_MAX) begin
      flen = LW'(FIND_MAX);
    end else begin
      flen = LW'(cfg.find_length);
    end
    if (32'(cfg.replace_length) > REPLACE_MAX) begin
      rlen = LW'(REPLACE_MAX);
    end else begin
      rlen = LW'(cfg.replace_length);
    end
    cnt_eff = (LW'(word_count) > flen) ? flen : LW'(word_count);
  end

  assign accept     = in_valid && !in_stall;
  assign in_delim   = is_delim(text_byte);
  assign out_free   = !out_valid || !out_stall;
  assign pos_last_s = (pos + LW'(1)) == lim;
  assign pos_last_r = (pos + LW'(1)) == rlen;
  assign byte_match = st_rd_data == cfg.find_word[BYTE_W*pos[SA_W-1:0] +: BYTE_W];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_delim) begin
            if (overlong) begin
              state_next = S_EMIT_BYTE;
            end else if (cnt_eff == flen) begin
              state_next = S_CMP;
            end else if (cnt_eff != '0) begin
              state_next = S_EMIT_STORE;
            end else begin
              state_next = S_EMIT_BYTE;
            end
          end else if (overlong) begin
            state_next = S_EMIT_BYTE;
          end else if (cnt_eff >= flen) begin
            state_next = S_EMIT_STORE;
          end
        end
      end
      S_CMP: begin
        if (!byte_match) begin
          state_next = S_EMIT_STORE;
        end else if (pos_last_s) begin
          state_next = (rlen != '0) ? S_EMIT_REPL : S_EMIT_BYTE;
        end
      end
      S_EMIT_STORE: begin
        if (out_free && pos_last_s) begin
          state_next = S_EMIT_BYTE;
        end
      end
      S_EMIT_REPL: begin
        if (out_free && pos_last_r) begin
          state_next = S_EMIT_BYTE;
        end
      end
      S_EMIT_BYTE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    pos_next        = pos;
    lim_next        = lim;
    held_byte_next  = held_byte;
    word_count_next = word_count;
    overlong_next   = overlong;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          held_byte_next = text_byte;
          pos_next       = '0;
          lim_next       = cnt_eff;
          if (in_delim) begin
            word_count_next = '0;
            overlong_next   = 1'b0;
          end else if (!overlong) begin
            if (cnt_eff < flen) begin
              word_count_next = CNT_W'(cnt_eff + LW'(1));
            end else begin
              word_count_next = '0;
              overlong_next   = 1'b1;
            end
          end
        end
      end
      S_CMP: begin
        if (!byte_match || pos_last_s) begin
          pos_next = '0;
        end else begin
          pos_next = pos + LW'(1);
        end
      end
      S_EMIT_STORE, S_EMIT_REPL: begin
        if (out_free) begin
          pos_next = pos + LW'(1);
        end
      end
      S_EMIT_BYTE: begin
        pos_next = pos;
      end
      default: pos_next = '0;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = 1'b1;
    load       = 1'b0;
    emit_byte  = held_byte;
    emit_last  = 1'b0;
    st_wr_en   = 1'b0;
    st_wr_addr = cnt_eff[SA_W-1:0];
    st_wr_data = text_byte;
    st_rd_addr = pos_next[SA_W-1:0];
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        st_wr_en = accept && !in_delim && !overlong && (cnt_eff < flen);
      end
      S_CMP: begin
        load = 1'b0;
      end
      S_EMIT_STORE: begin
        load      = out_free;
        emit_byte = st_rd_data;
      end
      S_EMIT_REPL: begin
        load      = out_free;
        emit_byte = cfg.replace_word[BYTE_W*pos[RA_W-1:0] +: BYTE_W];
      end
      S_EMIT_BYTE: begin
        load      = out_free;
        emit_last = 1'b1;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_count <= '0;
      overlong   <= 1'b0;
      out_valid  <= 1'b0;
      pos        <= '0;
    end else begin
      state      <= state_next;
      word_count <= word_count_next;
      overlong   <= overlong_next;
      pos        <= pos_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim       <= lim_next;
    held_byte <= held_byte_next;
    if (load) begin
      out_byte <= emit_byte;
      run_last <= emit_last;
    end
  end

  `WWR_ASSERT_NOW(a_count_bound, 1'b1, word_count <= CNT_W'(FIND_MAX), "word count out of range")
  `WWR_ASSERT_NOW(a_overlong_empty, overlong, word_count == '0, "overlong word with held bytes")
  `WWR_ASSERT_NEXT(a_delim_clears, accept && in_delim, word_count == '0 && !overlong, "delimiter did not end word")
  `WWR_ASSERT_NEXT(a_last_closes, state == S_EMIT_BYTE && out_free, state == S_IDLE && out_valid && run_last, "final byte not flagged")

endmodule

`default_nettype wire

/* rtl/core/whole_word_replace_stream.sv */
// channel  | handshake              | payload
// ---------+------------------------+---------------------
// in       | in_valid / in_stall    | text_byte
// out      | out_valid / out_stall  | out_byte, run_last
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a word byte that is only held is written to the word store; a delimiter after
// a word of n bytes goes through up to n compare steps and then its emitted bytes,
// all through the single byte compare unit and one output register
// overflow byte: the held bytes, then itself; a stall on out holds each emit step
// sync reset clears control state and sets config to its defaults (find length 1);
// word store needs no clear; top level of whole_word_replace_stream: config registers
// and instances; depends on wwr_pkg, wwr_store, wwr_ctrl
`timescale 1ns / 1ps
`default_nettype none

module whole_word_replace_stream
  import wwr_pkg::*;
#(
  parameter int FIND_MAX    = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    text_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 run_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int SA_W = (FIND_MAX > 1) ? $clog2(FIND_MAX) : 1;

  cfg_t              cfg;
  logic              st_wr_en;
  logic [SA_W-1:0]   st_wr_addr;
  logic [BYTE_W-1:0] st_wr_data;
  logic [SA_W-1:0]   st_rd_addr;
  logic [BYTE_W-1:0] st_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.find_word      <= '0;
      cfg.find_length    <= LEN_W'(1);
      cfg.replace_word   <= '0;
      cfg.replace_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIND_WORD:      cfg.find_word      <= cfg_data;
        REG_FIND_LENGTH:    cfg.find_length    <= cfg_data[LEN_W-1:0];
        REG_REPLACE_WORD:   cfg.replace_word   <= cfg_data;
        REG_REPLACE_LENGTH: cfg.replace_length <= cfg_data[LEN_W-1:0];
        default: cfg.find_word <= cfg.find_word;
      endcase
    end
  end

  wwr_store #(
    .FIND_MAX(FIND_MAX)
  ) u_store (
    .clk    (clk),
    .wr_en  (st_wr_en),
    .wr_addr(st_wr_addr),
    .wr_data(st_wr_data),
    .rd_addr(st_rd_addr),
    .rd_data(st_rd_data)
  );

  wwr_ctrl #(
    .FIND_MAX   (FIND_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .st_wr_en  (st_wr_en),
    .st_wr_addr(st_wr_addr),
    .st_wr_data(st_wr_data),
    .st_rd_addr(st_rd_addr),
    .st_rd_data(st_rd_data)
  );

endmodule

`default_nettype wire

/* tb/tb_whole_word_replace_stream.sv */
// testbench for whole_word_replace_stream: directed table then random word traffic, every
// output transaction checked against its table row's typed bytes or a local whole-word replace predictor
// depends on wwr_pkg and whole_word_replace_stream
`timescale 1ns / 1ps

module tb_whole_word_replace_stream;
  import wwr_pkg::*;

  localparam int FIND_MAX    = 8;
  localparam int REPLACE_MAX = 8;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int RAND_BYTES  = 410;

  typedef enum bit {ROW_TEXT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_reg_t          reg_idx;
    logic [WORD_W-1:0] data;
    logic [BYTE_W-1:0] ch;
    logic              typed;
    logic [1:0]        exp_n;
    logic [BYTE_W-1:0] exp0;
    logic [BYTE_W-1:0] exp1;
  } script_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } out_txn_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    text_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 run_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FIND_WORD;
  logic [WORD_W-1:0]    cfg_data = '0;

  whole_word_replace_stream #(
    .FIND_MAX(FIND_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .run_last(run_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of config and word state
  logic [WORD_W-1:0] cfg_find = '0;
  logic [LEN_W-1:0]  cfg_find_len = 4'd1;
  logic [WORD_W-1:0] cfg_repl = '0;
  logic [LEN_W-1:0]  cfg_repl_len = 4'd0;
  logic [BYTE_W-1:0] held_bytes [FIND_MAX];
  int                held_cnt = 0;
  bit                passing_through = 1'b0;
  logic [BYTE_W-1:0] step_bytes [FIND_MAX + 1];

  out_txn_t    pending_out [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic int find_len_eff();
    int n;
    n = int'(cfg_find_len);
    if (n == 0) n = 1;
    if (n > FIND_MAX) n = FIND_MAX;
    return n;
  endfunction

  function automatic int replace_step(input logic [BYTE_W-1:0] b);
    int  flen, cnt, rlen, n;
    bit  hit;
    flen = find_len_eff();
    cnt = held_cnt;
    if (cnt > flen) cnt = flen;
    n = 0;
    if (b == CHAR_SPACE || b == CHAR_EOT) begin
      if (!passing_through) begin
        hit = (cnt == flen);
        for (int i = 0; i < cnt; i++) begin
          if (held_bytes[i] != cfg_find[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          rlen = int'(cfg_repl_len);
          if (rlen > REPLACE_MAX) rlen = REPLACE_MAX;
          for (int i = 0; i < rlen; i++) begin
            step_bytes[n] = cfg_repl[8*i +: 8];
            n = n + 1;
          end
        end else begin
          for (int i = 0; i < cnt; i++) begin
            step_bytes[n] = held_bytes[i];
            n = n + 1;
          end
        end
      end
      step_bytes[n] = b;
      n = n + 1;
      held_cnt = 0;
      passing_through = 1'b0;
    end else if (passing_through) begin
      step_bytes[n] = b;
      n = n + 1;
    end else if (cnt < flen) begin
      held_bytes[cnt] = b;
      held_cnt = cnt + 1;
    end else begin
      for (int i = 0; i < cnt; i++) begin
        step_bytes[n] = held_bytes[i];
        n = n + 1;
      end
      step_bytes[n] = b;
      n = n + 1;
      held_cnt = 0;
      passing_through = 1'b1;
    end
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_word_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(1, 255));
    if (b == CHAR_SPACE) b = 8'h21;
    return b;
  endfunction

  function automatic void add_text(input logic [BYTE_W-1:0] ch, input bit typed,
                                   input int tn, input logic [BYTE_W-1:0] t0,
                                   input logic [BYTE_W-1:0] t1);
    script_row_t row;
    row = '0;
    row.kind = ROW_TEXT;
    row.ch = ch;
    row.typed = typed;
    row.exp_n = 2'(tn);
    row.exp0 = t0;
    row.exp1 = t1;
    script.push_back(row);
  endfunction

  function automatic void add_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] data);
    script_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.data = data;
    script.push_back(row);
  endfunction

  task automatic send_text(input logic [BYTE_W-1:0] ch, input bit typed, input int tn,
                           input logic [BYTE_W-1:0] t0, input logic [BYTE_W-1:0] t1);
    int gap, n;
    gap = 0;
    while (!calm && $urandom_range(99) < 18) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= ch;
    do @(posedge clk); while (in_stall);
    n = replace_step(ch);
    if (typed) begin
      if (tn > 0) pending_out.push_back({t0, tn == 1});
      if (tn > 1) pending_out.push_back({t1, 1'b1});
    end else begin
      for (int i = 0; i < n; i++) pending_out.push_back({step_bytes[i], i == n - 1});
    end
    bytes_sent++;
  endtask

  // only called at a clock edge with nothing else driven on in_valid
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FIND_WORD:      cfg_find = data;
      REG_FIND_LENGTH:    cfg_find_len = data[LEN_W-1:0];
      REG_REPLACE_WORD:   cfg_repl = data;
      REG_REPLACE_LENGTH: cfg_repl_len = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // receiver side stall, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin : out_check
    out_txn_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction: byte %h last %b", out_byte, run_last);
      end else begin
        want = pending_out.pop_front();
        if (out_byte !== want.ch || run_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected byte %h last %b, got byte %h last %b",
                     want.ch, want.last, out_byte, run_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    script_row_t       row;
    bit                need_drain;
    int                phase, phase_end, flen, r, wl, j;
    logic [WORD_W-1:0] fw, rw, fl_data, rl_data;
    logic [BYTE_W-1:0] b;

    // reset config: find one byte 00, empty replacement
    add_text(CHAR_SPACE, 1, 1, CHAR_SPACE, 8'h00);
    add_text(CHAR_EOT, 1, 1, CHAR_EOT, 8'h00);
    add_text(8'h61, 1, 0, 8'h00, 8'h00);
    add_text(CHAR_SPACE, 1, 2, 8'h61, CHAR_SPACE);
    add_text(8'hFF, 1, 0, 8'h00, 8'h00);
    add_text(8'h01, 1, 2, 8'hFF, 8'h01);
    add_text(8'h80, 1, 1, 8'h80, 8'h00);
    add_text(CHAR_EOT, 1, 1, CHAR_EOT, 8'h00);
    // plain match, then overlong word ended by end of text
    add_reg(REG_FIND_WORD, 64'h0000_0000_0074_6163);
    add_reg(REG_FIND_LENGTH, 64'd3);
    add_reg(REG_REPLACE_WORD, 64'h0000_0000_0067_6F64);
    add_reg(REG_REPLACE_LENGTH, 64'd3);
    add_text(8'h63, 0, 0, 8'h00, 8'h00);
    add_text(8'h61, 0, 0, 8'h00, 8'h00);
    add_text(8'h74, 0, 0, 8'h00, 8'h00);
    add_text(CHAR_SPACE, 0, 0, 8'h00, 8'h00);
    add_text(8'h63, 0, 0, 8'h00, 8'h00);
    add_text(8'h61, 0, 0, 8'h00, 8'h00);
    add_text(8'h74, 0, 0, 8'h00, 8'h00);
    add_text(8'h73, 0, 0, 8'h00, 8'h00);
    add_text(CHAR_EOT, 0, 0, 8'h00, 8'h00);
    // find length zero, replacement length above max
    add_reg(REG_FIND_WORD, 64'h0000_0000_0000_0078);
    add_reg(REG_FIND_LENGTH, 64'd0);
    add_reg(REG_REPLACE_WORD, '1);
    add_reg(REG_REPLACE_LENGTH, '1);
    add_text(8'h78, 0, 0, 8'h00, 8'h00);
    add_text(CHAR_SPACE, 0, 0, 8'h00, 8'h00);
    // find length above max, empty replacement drops the word
    add_reg(REG_FIND_WORD, 64'hFF10_0804_0201_7FFE);
    add_reg(REG_FIND_LENGTH, 64'd15);
    add_reg(REG_REPLACE_LENGTH, 64'd0);
    add_text(8'hFE, 0, 0, 8'h00, 8'h00);
    add_text(8'h7F, 0, 0, 8'h00, 8'h00);
    add_text(8'h01, 0, 0, 8'h00, 8'h00);
    add_text(8'h02, 0, 0, 8'h00, 8'h00);
    add_text(8'h04, 0, 0, 8'h00, 8'h00);
    add_text(8'h08, 0, 0, 8'h00, 8'h00);
    add_text(8'h10, 0, 0, 8'h00, 8'h00);
    add_text(8'hFF, 0, 0, 8'h00, 8'h00);
    add_text(CHAR_SPACE, 0, 0, 8'h00, 8'h00);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    need_drain = 1'b0;
    for (int k = 0; k < script.size(); k++) begin
      row = script[k];
      if (row.kind == ROW_REG) begin
        if (need_drain) drain();
        need_drain = 1'b0;
        write_reg(row.reg_idx, row.data);
      end else begin
        send_text(row.ch, row.typed, row.exp_n, row.exp0, row.exp1);
        need_drain = 1'b1;
      end
    end

    phase = 0;
    bytes_sent = 0;
    while (bytes_sent < RAND_BYTES) begin
      drain();
      fl_data = {$urandom, $urandom};
      rl_data = {$urandom, $urandom};
      rw = {$urandom, $urandom};
      for (int i = 0; i < 8; i++) fw[8*i +: 8] = rand_word_byte();
      case (phase)
        0: begin
          fw = '1;
          rw = '1;
          fl_data[LEN_W-1:0] = 4'd8;
          rl_data[LEN_W-1:0] = 4'd8;
        end
        1: begin
          rw = '0;
          fl_data[LEN_W-1:0] = 4'd1;
          rl_data[LEN_W-1:0] = 4'd0;
        end
        default: begin
          if ($urandom_range(3) == 0) fw = {$urandom, $urandom};
          if ($urandom_range(99) < 70) fl_data[LEN_W-1:0] = LEN_W'($urandom_range(1, 4));
          else fl_data[LEN_W-1:0] = LEN_W'($urandom_range(0, 15));
          rl_data[LEN_W-1:0] = LEN_W'($urandom_range(0, 15));
        end
      endcase
      write_reg(REG_FIND_WORD, fw);
      write_reg(REG_FIND_LENGTH, fl_data);
      write_reg(REG_REPLACE_WORD, rw);
      write_reg(REG_REPLACE_LENGTH, rl_data);
      calm <= (phase == 2);
      if (phase == 3) hold_reqs <= hold_reqs + 1;
      flen = find_len_eff();
      phase_end = bytes_sent + $urandom_range(40, 70);
      while (bytes_sent < phase_end) begin
        r = $urandom_range(99);
        if (r < 50) begin
          // the find word, or a near miss with one byte altered
          j = (r < 35) ? -1 : $urandom_range(0, flen - 1);
          for (int i = 0; i < flen; i++) begin
            b = cfg_find[8*i +: 8];
            if (i == j) begin
              b = ($urandom_range(1) == 0) ? (b ^ 8'h20) : rand_word_byte();
              if (b == CHAR_SPACE || b == CHAR_EOT) b = 8'h5A;
            end
            send_text(b, 0, 0, 8'h00, 8'h00);
          end
        end else if (r < 85) begin
          wl = $urandom_range(0, flen + 3);
          for (int i = 0; i < wl; i++) send_text(rand_word_byte(), 0, 0, 8'h00, 8'h00);
        end else begin
          wl = $urandom_range(1, 4);
          for (int i = 0; i < wl; i++) begin
            send_text(BYTE_W'($urandom_range(0, 255)), 0, 0, 8'h00, 8'h00);
          end
        end
        if (r < 85) begin
          b = ($urandom_range(4) == 0) ? CHAR_EOT : CHAR_SPACE;
          send_text(b, 0, 0, 8'h00, 8'h00);
        end
      end
      phase++;
    end
    drain();

    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/wwr_pkg.sv
rtl/core/wwr_store.sv
rtl/core/wwr_ctrl.sv
rtl/core/whole_word_replace_stream.sv
tb/tb_whole_word_replace_stream.sv
